// ----- rtl/core/tdl_pkg.sv -----
// Shared types and constants for the timed deny-list table.
// No dependencies; imported by tdl_ctrl, the top level and the bench.
package tdl_pkg;

	// Operation codes carried in the kind field
	localparam logic [2:0] KIND_ADD    = 3'd0;
	localparam logic [2:0] KIND_LOOKUP = 3'd1;
	localparam logic [2:0] KIND_MERGE  = 3'd2;
	localparam logic [2:0] KIND_EXPIRE = 3'd3;
	localparam logic [2:0] KIND_COUNT  = 3'd4;

	localparam int          FP_PORT_W    = 64;
	localparam logic [31:0] GRACE_RESET  = 32'd86400000;
	localparam logic [31:0] NUMBER_MAX   = 32'd31;

	// One input word as latched by the sequencer
	typedef struct packed {
		logic [2:0]           kind;
		logic [FP_PORT_W-1:0] fingerprint;
		logic [31:0]          grace_ms;
		logic [31:0]          now_ms;
	} item_t;

	// One result word
	typedef struct packed {
		logic       hit;
		logic [4:0] number;
	} result_t;

	// Sequencer status toward the top level
	typedef struct packed {
		logic idle;
		logic done;
	} ctrl_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

// ----- rtl/core/tdl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/tdl_grace_unit.sv -----
// Shared grace unit: remaining grace from start, grace and current time.
// Wrap-safe 32-bit elapsed time; reads 0 once expired. No dependencies.
module tdl_grace_unit (
	input  logic [31:0] now_ms,
	input  logic [31:0] start_ms,
	input  logic [31:0] grace_ms,
	output logic [31:0] left_ms
);

	logic [31:0] elapsed;

	// elapsed wraps naturally in 32 bits
	assign elapsed = now_ms - start_ms;
	assign left_ms = (elapsed >= grace_ms) ? 32'd0 : (grace_ms - elapsed);

endmodule

// ----- rtl/core/tdl_ctrl.sv -----
// Scan sequencer: walks the slot table once per word through the shared grace unit,
// then performs at most one table write. Depends on tdl_pkg, tdl_ram, tdl_grace_unit.
module tdl_ctrl import tdl_pkg::*; #(
	parameter int N   = 16,
	parameter int FPW = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_t       item,
	input  logic [31:0] grace_period,
	input  logic        res_take,
	output ctrl_stat_t  stat,
	output result_t     result
);

	localparam int IDXW = (N > 1) ? $clog2(N) : 1;
	localparam int CNTW = $clog2(N + 1);
	localparam int RW   = FPW + 64;
	localparam logic [IDXW:0]   ISS_END  = (IDXW + 1)'(N);
	localparam logic [IDXW-1:0] IDX_LAST = IDXW'(N - 1);

	state_t            state_q;
	logic [2:0]        kind_q;
	logic [FPW-1:0]    fp_q;
	logic [31:0]       gc_q;
	logic [31:0]       now_q;
	logic              wr_en_q;
	logic [IDXW:0]     iss_q;
	logic              go_s1, go_s2;
	logic [IDXW-1:0]   idx_s1, idx_s2;
	logic              v_s2, m_s2;
	logic [31:0]       left_s2;
	logic [N-1:0]      valid_q;
	logic              found_q, free_q, min_set_q, hit_q;
	logic [IDXW-1:0]   fidx_q, free_idx_q, min_idx_q;
	logic [31:0]       have_q, min_q;
	logic [CNTW-1:0]   cnt_q;

	logic              rd_en, ram_we;
	logic [RW-1:0]     ram_rdata, ram_wdata;
	logic [31:0]       left_c, wgrace, gc_c, cnt_ext;
	logic [IDXW-1:0]   widx;
	logic              is_add, is_lookup, is_merge, is_exp, is_cnt;
	logic              dead, match_hit, free_hit, drop, cnt_inc, scan_last;

	// Slot store: {fingerprint, start, grace}
	tdl_ram #(
		.WIDTH(RW),
		.DEPTH(N)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (iss_q[IDXW-1:0]),
		.rdata (ram_rdata)
	);

	tdl_grace_unit u_grace (
		.now_ms   (now_q),
		.start_ms (ram_rdata[63:32]),
		.grace_ms (ram_rdata[31:0]),
		.left_ms  (left_c)
	);

	// Kind decode
	assign is_add    = (kind_q == KIND_ADD);
	assign is_lookup = (kind_q == KIND_LOOKUP);
	assign is_merge  = (kind_q == KIND_MERGE);
	assign is_exp    = (kind_q == KIND_EXPIRE);
	assign is_cnt    = (kind_q == KIND_COUNT);

	// Per-slot decisions at stage 2; add sweeps and searches in the same pass
	assign dead      = (left_s2 == 32'd0);
	assign match_hit = v_s2 && m_s2 && (!is_add || !dead);
	assign free_hit  = !v_s2 || (is_add && dead);
	assign drop      = v_s2 && dead && (is_add || is_exp);
	assign cnt_inc   = (is_exp && v_s2 && dead) || (is_cnt && v_s2 && !dead);
	assign scan_last = go_s2 && (idx_s2 == IDX_LAST);

	assign rd_en = (state_q == ST_SCAN) && (iss_q < ISS_END);

	// Grace to store: add uses the full period, merge the clamped value
	assign gc_c = (item.kind == KIND_ADD) ? grace_period :
	              ((item.grace_ms > grace_period) ? grace_period : item.grace_ms);

	// Write target: matched slot, else first free, else least grace left
	assign widx   = found_q ? fidx_q : (free_q ? free_idx_q : min_idx_q);
	assign wgrace = (found_q && is_merge && (have_q > gc_q)) ? have_q : gc_q;
	assign ram_we    = (state_q == ST_WRITE) && wr_en_q;
	assign ram_wdata = {fp_q, now_q, wgrace};

	// Sequencer and valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			go_s1   <= 1'b0;
			go_s2   <= 1'b0;
		end else begin
			go_s1 <= rd_en;
			go_s2 <= go_s1;
			if (go_s2 && drop) begin
				valid_q[idx_s2] <= 1'b0;
			end
			if (ram_we) begin
				valid_q[widx] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Word latch, scan pipeline and search results
	always_ff @(posedge clk) begin
		idx_s1  <= iss_q[IDXW-1:0];
		idx_s2  <= idx_s1;
		v_s2    <= valid_q[idx_s1];
		m_s2    <= (ram_rdata[RW-1 -: FPW] == fp_q);
		left_s2 <= left_c;
		if (rd_en) begin
			iss_q <= iss_q + 1'b1;
		end
		if (start && (state_q == ST_IDLE)) begin
			kind_q    <= item.kind;
			fp_q      <= item.fingerprint[FPW-1:0];
			gc_q      <= gc_c;
			now_q     <= item.now_ms;
			wr_en_q   <= (item.kind == KIND_ADD) ||
			             ((item.kind == KIND_MERGE) && (item.grace_ms != 32'd0));
			iss_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			min_set_q <= 1'b0;
			hit_q     <= 1'b0;
			cnt_q     <= '0;
		end else if (go_s2) begin
			if (match_hit && !found_q && (is_add || is_merge || is_lookup)) begin
				found_q <= 1'b1;
				fidx_q  <= idx_s2;
				have_q  <= left_s2;
				hit_q   <= is_lookup && !dead;
			end
			if (free_hit && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s2;
			end
			if (!min_set_q || (left_s2 < min_q)) begin
				min_set_q <= 1'b1;
				min_q     <= left_s2;
				min_idx_q <= idx_s2;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Result, count saturated to the field width
	assign cnt_ext       = 32'(cnt_q);
	assign result.hit    = hit_q;
	assign result.number = (cnt_ext > NUMBER_MAX) ? 5'(NUMBER_MAX) : 5'(cnt_ext);
	assign stat.idle     = (state_q == ST_IDLE);
	assign stat.done     = (state_q == ST_DONE);

endmodule

// ----- rtl/core/timed_deny_list_table_unit.sv -----
// Top level of the timed deny-list table: config register, handshakes, output register.
// Depends on tdl_pkg and tdl_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word: kind, fingerprint,
//   grace_ms, now_ms. A word is taken when in_valid is high and in_stall low.
//   Output channel (out_valid / out_stall) returns exactly one word per input:
//   hit and number. The word is taken when out_valid is high and out_stall low.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes grace_period_ms;
//   cfg_ready is always high. Write it only while the block is idle.
// Operation:
//   Every word makes one pass over the table through the shared grace unit,
//   one slot per cycle, then passes through the write state to done. The
//   table RAM's single read port sets the scan rate; in_stall stays high
//   while a word is in work, so the next word is accepted only once the
//   sequencer has handed the last result to the output register.
// Reset:
//   arst_n clears all slot valid marks and loads grace_period_ms = 86400000.
// Stalls:
//   A finished result sits in the output register; the next word is accepted
//   meanwhile, and its result waits in the sequencer until the register frees.
module timed_deny_list_table_unit import tdl_pkg::*; #(
	parameter int TABLE_ENTRIES    = 16,
	parameter int FINGERPRINT_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           kind,
	input  logic [FP_PORT_W-1:0] fingerprint,
	input  logic [31:0]          grace_ms,
	input  logic [31:0]          now_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic [4:0]           number,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data
);

	logic [31:0] grace_period_q;
	logic        out_valid_q;
	result_t     out_q;
	result_t     result;
	ctrl_stat_t  stat;
	item_t       item;
	logic        start, res_take;

	assign item = '{kind: kind, fingerprint: fingerprint, grace_ms: grace_ms, now_ms: now_ms};
	assign start     = in_valid && stat.idle;
	assign in_stall  = !stat.idle;
	assign res_take  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	tdl_ctrl #(
		.N   (TABLE_ENTRIES),
		.FPW (FINGERPRINT_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.grace_period (grace_period_q),
		.res_take     (res_take),
		.stat         (stat),
		.result       (result)
	);

	// Config register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_period_q <= GRACE_RESET;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				grace_period_q <= cfg_data;
			end
			if (stat.done && res_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (stat.done && res_take) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_q.hit;
	assign number    = out_q.number;

endmodule

// ----- tb/timed_deny_list_table_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for timed_deny_list_table_unit: random and directed deny-list traffic,
// predicted against a local copy of the slot table. Depends on tdl_pkg and the unit RTL.
module timed_deny_list_table_unit_tb;
	import tdl_pkg::*;

	localparam int ENTRIES         = 16;
	localparam int FP_BITS         = 64;
	localparam int RESET_CYCLES    = 11;
	localparam int DRAIN_CYCLES    = 40;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int REPORT_LIMIT    = 200;
	localparam int FP_POOL         = 24;

	localparam logic [FP_PORT_W-1:0] FP_MASK  = {FP_PORT_W{1'b1}} >> (FP_PORT_W - FP_BITS);
	localparam logic [FP_PORT_W-1:0] FP_ONES  = {FP_PORT_W{1'b1}};
	localparam logic [31:0]          MS_ONES  = 32'hFFFF_FFFF;
	// kinds with no operation behind them
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

	// queued word: either a table operation or a write of the grace register
	typedef struct {
		bit          is_cfg;
		logic [31:0] cfg_value;
		item_t       word;
	} queued_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [2:0]           kind        = KIND_ADD;
	logic [FP_PORT_W-1:0] fingerprint = '0;
	logic [31:0]          grace_ms    = '0;
	logic [31:0]          now_ms      = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 hit;
	logic [4:0]           number;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [31:0]          cfg_data    = '0;

	queued_t queued_words[$];
	result_t due_verdicts[$];

	// mirror of the slot table and the grace register
	logic                 tbl_valid [ENTRIES];
	logic [FP_PORT_W-1:0] tbl_fp    [ENTRIES];
	logic [31:0]          tbl_start [ENTRIES];
	logic [31:0]          tbl_grace [ENTRIES];
	logic [31:0]          grace_reg;

	// handshake flags seen at the last rising edge
	logic in_fire  = 1'b0;
	logic cfg_fire = 1'b0;

	int unsigned fail_count   = 0;
	int unsigned result_count = 0;
	int unsigned quiet_cycles = 0;

	// sender burst shaping and receiver stall pattern
	int unsigned burst_left  = 0;
	int unsigned gap_left    = 0;
	int unsigned stall_mode  = 0;
	int unsigned mode_left   = 0;
	int unsigned run_left    = 0;
	logic        run_level   = 1'b0;

	// stimulus generator state
	logic [31:0]          gen_now = '0;
	logic [FP_PORT_W-1:0] fp_pool [FP_POOL];

	timed_deny_list_table_unit #(
		.TABLE_ENTRIES   (ENTRIES),
		.FINGERPRINT_BITS(FP_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.fingerprint(fingerprint),
		.grace_ms   (grace_ms),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.number     (number),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Table predictor
	// ---------------------------------------------------------------

	// grace left in a slot, wrap-safe elapsed time
	function automatic logic [31:0] grace_left_at(int e, logic [31:0] at_ms);
		logic [31:0] elapsed;
		elapsed = at_ms - tbl_start[e];
		return (elapsed >= tbl_grace[e]) ? 32'd0 : tbl_grace[e] - elapsed;
	endfunction

	function automatic int find_entry(logic [FP_PORT_W-1:0] fp);
		int found;
		found = -1;
		for (int e = ENTRIES - 1; e >= 0; e--)
			if (tbl_valid[e] && tbl_fp[e] == fp)
				found = e;
		return found;
	endfunction

	// clear dead slots, return how many went
	function automatic int drop_dead(logic [31:0] at_ms);
		int dropped;
		dropped = 0;
		for (int e = 0; e < ENTRIES; e++) begin
			if (tbl_valid[e] && grace_left_at(e, at_ms) == 0) begin
				tbl_valid[e] = 1'b0;
				tbl_fp[e]    = '0;
				tbl_start[e] = '0;
				tbl_grace[e] = '0;
				dropped++;
			end
		end
		return dropped;
	endfunction

	// merge-style insert: keep longer grace, else first free, else evict least grace
	function automatic void place_entry(logic [FP_PORT_W-1:0] fp, logic [31:0] grace,
			logic [31:0] at_ms);
		int          e;
		logic [31:0] have;
		e = find_entry(fp);
		if (e >= 0) begin
			have         = grace_left_at(e, at_ms);
			tbl_start[e] = at_ms;
			tbl_grace[e] = (have > grace) ? have : grace;
		end else begin
			for (int i = 0; i < ENTRIES; i++)
				if (e < 0 && !tbl_valid[i])
					e = i;
			if (e < 0) begin
				e = 0;
				for (int i = 1; i < ENTRIES; i++)
					if (grace_left_at(i, at_ms) < grace_left_at(e, at_ms))
						e = i;
			end
			tbl_fp[e]    = fp;
			tbl_start[e] = at_ms;
			tbl_grace[e] = grace;
			tbl_valid[e] = 1'b1;
		end
	endfunction

	function automatic result_t predict_verdict(item_t w);
		result_t              r;
		logic [FP_PORT_W-1:0] fp;
		logic [31:0]          g;
		int                   e;
		int                   tally;
		r     = '0;
		fp    = w.fingerprint & FP_MASK;
		g     = w.grace_ms;
		tally = 0;
		case (w.kind)
			KIND_ADD: begin
				void'(drop_dead(w.now_ms));
				e = find_entry(fp);
				if (e >= 0) begin
					tbl_start[e] = w.now_ms;
					tbl_grace[e] = grace_reg;
				end else begin
					place_entry(fp, grace_reg, w.now_ms);
				end
			end
			KIND_LOOKUP: begin
				e     = find_entry(fp);
				r.hit = (e >= 0) && (grace_left_at(e, w.now_ms) != 0);
			end
			KIND_MERGE: begin
				if (g != 0) begin
					if (g > grace_reg)
						g = grace_reg;
					place_entry(fp, g, w.now_ms);
				end
			end
			KIND_EXPIRE: begin
				tally = drop_dead(w.now_ms);
			end
			KIND_COUNT: begin
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i] && grace_left_at(i, w.now_ms) != 0)
						tally++;
			end
			default: begin
			end
		endcase
		r.number = (tally > NUMBER_MAX) ? 5'(NUMBER_MAX) : 5'(tally);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	task automatic push_word(logic [2:0] k, logic [FP_PORT_W-1:0] fp, logic [31:0] g,
			logic [31:0] at_ms);
		queued_t q;
		q.is_cfg           = 1'b0;
		q.cfg_value        = '0;
		q.word.kind        = k;
		q.word.fingerprint = fp;
		q.word.grace_ms    = g;
		q.word.now_ms      = at_ms;
		queued_words.push_back(q);
	endtask

	task automatic push_cfg(logic [31:0] value);
		queued_t q;
		q.is_cfg    = 1'b1;
		q.cfg_value = value;
		q.word      = '0;
		queued_words.push_back(q);
	endtask

	// Mostly fingerprints from a small pool so that lookups hit and the table fills;
	// time moves forward in steps scaled to the grace, with odd jumps and step-backs.
	task automatic push_random_phase(logic [31:0] full_grace, int unsigned step_div,
			int unsigned n_words);
		logic [2:0]           k;
		logic [FP_PORT_W-1:0] fp;
		logic [31:0]          g;
		logic [31:0]          span;
		int unsigned          pick;
		span = (full_grace < 32'd64) ? 32'd64 : full_grace;
		for (int p = 2; p < FP_POOL; p++)
			fp_pool[p] = {$urandom, $urandom};
		for (int unsigned n = 0; n < n_words; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				gen_now = $urandom;
			else if (pick < 10)
				gen_now = gen_now - $urandom_range(0, 3);
			else
				gen_now = gen_now + ($urandom % (span / step_div + 1));

			pick = $urandom_range(0, 99);
			if (pick < 30)
				k = KIND_ADD;
			else if (pick < 55)
				k = KIND_MERGE;
			else if (pick < 80)
				k = KIND_LOOKUP;
			else if (pick < 88)
				k = KIND_EXPIRE;
			else if (pick < 96)
				k = KIND_COUNT;
			else
				k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));

			if ($urandom_range(0, 99) < 85)
				fp = fp_pool[$urandom_range(0, FP_POOL - 1)];
			else
				fp = {$urandom, $urandom};

			pick = $urandom_range(0, 99);
			if (k != KIND_MERGE)
				g = $urandom;
			else if (pick < 8)
				g = '0;
			else if (pick < 20)
				g = $urandom;
			else if (pick < 28)
				g = full_grace;
			else if (pick < 32)
				g = MS_ONES;
			else if (full_grace == 0)
				g = $urandom;
			else
				g = $urandom_range(1, full_grace);

			push_word(k, fp, g, gen_now);
		end
	endtask

	// ---------------------------------------------------------------
	// Stimulus, reset and end of run
	// ---------------------------------------------------------------
	initial begin : stimulus
		logic [FP_PORT_W-1:0] fp_a;
		fp_a       = 64'h0123_4567_89AB_CDEF;
		fp_pool[0] = '0;
		fp_pool[1] = FP_ONES;

		// empty table, re-arm, grace edge, merge clamp / ignore / keep longer, wrap sweep
		push_word(KIND_COUNT,  '0,      '0,      32'd0);
		push_word(KIND_LOOKUP, FP_ONES, MS_ONES, 32'd0);
		push_word(KIND_ADD,    '0,      '0,      32'd0);
		push_word(KIND_ADD,    FP_ONES, '0,      32'd100);
		push_word(KIND_ADD,    '0,      MS_ONES, 32'd50);
		push_word(KIND_LOOKUP, '0,      '0,      32'd50 + GRACE_RESET - 32'd1);
		push_word(KIND_LOOKUP, '0,      '0,      32'd50 + GRACE_RESET);
		push_word(KIND_MERGE,  FP_ONES, '0,      32'd200);
		push_word(KIND_MERGE,  fp_a,    MS_ONES, 32'd300);
		push_word(KIND_MERGE,  FP_ONES, 32'd5,   32'd400);
		push_word(KIND_COUNT,  '0,      '0,      32'd500);
		push_word(KIND_EXPIRE, '0,      '0,      MS_ONES);
		for (logic [3:0] k = {1'b0, KIND_SPARE_FIRST}; k <= {1'b0, KIND_SPARE_LAST}; k++)
			push_word(k[2:0], {$urandom, $urandom}, $urandom, $urandom);
		push_word(KIND_COUNT,  '0,      '0,      MS_ONES);
		gen_now = 32'd1000;
		push_random_phase(GRACE_RESET, 40, 220);

		// shortest grace: alive only at the start instant
		push_cfg(32'd1);
		push_word(KIND_ADD,    fp_a, '0, gen_now);
		push_word(KIND_LOOKUP, fp_a, '0, gen_now);
		push_word(KIND_LOOKUP, fp_a, '0, gen_now + 32'd1);
		push_random_phase(32'd1, 4, 150);

		// longest grace: dead only one tick before its start
		push_cfg(MS_ONES);
		push_word(KIND_ADD,    fp_a, '0, 32'd5);
		push_word(KIND_LOOKUP, fp_a, '0, 32'd4);
		push_word(KIND_LOOKUP, fp_a, '0, 32'd3);
		gen_now = 32'd3;
		push_random_phase(MS_ONES, 8, 260);

		// zero grace register: adds and merges store dead entries
		push_cfg('0);
		push_word(KIND_ADD,    fp_a, '0,    gen_now);
		push_word(KIND_LOOKUP, fp_a, '0,    gen_now);
		push_word(KIND_MERGE,  fp_a, 32'd9, gen_now + 32'd1);
		push_word(KIND_COUNT,  '0,   '0,    gen_now + 32'd1);
		push_random_phase('0, 4, 60);

		push_cfg(32'd1000);
		push_random_phase(32'd1000, 40, 250);

		begin : rand_grace
			logic [31:0] g;
			g = $urandom_range(2, 32'hFFFF_FFFE);
			push_cfg(g);
			push_random_phase(g, 30, 200);
		end

		push_cfg(GRACE_RESET);
		push_random_phase(GRACE_RESET, 20, 200);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		while (queued_words.size() != 0 || due_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("timed_deny_list_table_unit_tb: PASS");
		else
			$display("timed_deny_list_table_unit_tb: FAIL");
		$finish;
	end

	// ---------------------------------------------------------------
	// Driver: words and register writes, bursts with random gaps
	// ---------------------------------------------------------------
	always @(negedge clk) begin : driver
		if (arst_n) begin
			// retire the word taken at the last rising edge
			if (in_fire || cfg_fire) begin
				void'(queued_words.pop_front());
				if (in_fire && burst_left > 0)
					burst_left--;
			end
			if (burst_left == 0) begin
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				burst_left = $urandom_range(1, 20);
			end

			if (in_valid && !in_fire) begin
				// stalled word stays as it is
			end else if (cfg_valid && !cfg_fire) begin
				// register write waits for ready
			end else if (queued_words.size() == 0) begin
				in_valid  <= 1'b0;
				cfg_valid <= 1'b0;
			end else if (queued_words[0].is_cfg) begin
				// write only once every result is back
				in_valid  <= 1'b0;
				cfg_valid <= (due_verdicts.size() == 0);
				cfg_data  <= queued_words[0].cfg_value;
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid  <= 1'b0;
				cfg_valid <= 1'b0;
			end else begin
				in_valid    <= 1'b1;
				cfg_valid   <= 1'b0;
				kind        <= queued_words[0].word.kind;
				fingerprint <= queued_words[0].word.fingerprint;
				grace_ms    <= queued_words[0].word.grace_ms;
				now_ms      <= queued_words[0].word.now_ms;
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver stall: free, coin-flip, or long runs, switching now and then
	// ---------------------------------------------------------------
	always @(negedge clk) begin : receiver
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(64, 256);
		end
		mode_left--;
		if (run_left == 0) begin
			run_level = ~run_level;
			run_left  = $urandom_range(1, 40);
		end
		run_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= run_level;
		endcase
	end

	// ---------------------------------------------------------------
	// Monitor: predict on accept, check each returned word, watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t want;
		item_t   seen;
		if (!arst_n) begin
			grace_reg = GRACE_RESET;
			for (int e = 0; e < ENTRIES; e++) begin
				tbl_valid[e] = 1'b0;
				tbl_fp[e]    = '0;
				tbl_start[e] = '0;
				tbl_grace[e] = '0;
			end
		end else begin
			in_fire  <= in_valid && !in_stall;
			cfg_fire <= cfg_valid && cfg_ready;

			if (cfg_valid && cfg_ready)
				grace_reg = cfg_data;

			if (out_valid && !out_stall) begin
				result_count++;
				if (due_verdicts.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: word %0d arrived with nothing expected (hit %0b number %0d)",
							$time, result_count, hit, number);
				end else begin
					want = due_verdicts.pop_front();
					if (hit !== want.hit) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: word %0d hit expected %0b actual %0b",
								$time, result_count, want.hit, hit);
					end
					if (number !== want.number) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: word %0d number expected %0d actual %0d",
								$time, result_count, want.number, number);
					end
				end
			end

			if (in_valid && !in_stall) begin
				seen.kind        = kind;
				seen.fingerprint = fingerprint;
				seen.grace_ms    = grace_ms;
				seen.now_ms      = now_ms;
				due_verdicts.push_back(predict_verdict(seen));
			end

			// no handshake on any channel for too long
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: watchdog, %0d cycles without a handshake", $time, quiet_cycles);
				$display("timed_deny_list_table_unit_tb: FAIL");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
rtl/core/tdl_pkg.sv
rtl/core/tdl_ram.sv
rtl/core/tdl_grace_unit.sv
rtl/core/tdl_ctrl.sv
rtl/core/timed_deny_list_table_unit.sv
tb/timed_deny_list_table_unit_tb.sv
